/* hdl/hcfc_pkg.sv */
// shared types, codes and crc helper for the header crc8 frame codec
package hcfc_pkg;

	localparam logic [7:0] FRAME_HEADER = 8'hCC;
	localparam logic [7:0] CRC_POLY     = 8'hD5;

	// item commands
	localparam logic [1:0] CMD_TX      = 2'd0;
	localparam logic [1:0] CMD_RX      = 2'd1;
	localparam logic [1:0] CMD_RESTART = 2'd2;

	// result kinds
	localparam logic [1:0] KIND_TX      = 2'd0;
	localparam logic [1:0] KIND_RX_DATA = 2'd1;
	localparam logic [1:0] KIND_RX_END  = 2'd2;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] data;
		logic       first;
		logic       final_req;
	} item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] out_byte;
		logic       run_end;
	} result_t;

	typedef struct packed {
		logic [7:0] tx_crc;
		logic [7:0] rx_crc;
		logic       rx_in_frame;
	} state_t;

	// one byte through crc-8/dvb-s2, msb first
	function automatic logic [7:0] crc_fold(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

	// crc of the header byte alone
	localparam logic [7:0] HDR_CRC = crc_fold(8'h00, FRAME_HEADER);

endpackage

/* hdl/hcfc_ifs.sv */
// valid/ready channel interfaces for request and result items
interface hcfc_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] cmd;
	logic [7:0] data;
	logic       first;
	logic       final_req;

	modport source (output valid, output cmd, output data, output first, output final_req,
		input ready);
	modport sink (input valid, input cmd, input data, input first, input final_req,
		output ready);
endinterface

interface hcfc_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] out_byte;
	logic       run_end;

	modport source (output valid, output kind, output out_byte, output run_end, input ready);
	modport sink (input valid, input kind, input out_byte, input run_end, output ready);
endinterface

/* hdl/hcfc_calc.sv */
// result selection and next state for the item held in stage 1
module hcfc_calc (
	input  hcfc_pkg::item_t   item,
	input  hcfc_pkg::state_t  st,
	input  logic [1:0]        idx,
	output logic              has_res,
	output hcfc_pkg::result_t res,
	output hcfc_pkg::state_t  st_next
);

	localparam logic [1:0] SLOT_HDR  = 2'd0;
	localparam logic [1:0] SLOT_DATA = 2'd1;
	localparam logic [1:0] SLOT_CRC  = 2'd2;

	logic [7:0] tx_base;
	logic [7:0] tx_new;
	logic [7:0] rx_new;
	logic [1:0] slot;
	logic [1:0] last_idx;

	assign tx_base  = item.first ? hcfc_pkg::HDR_CRC : st.tx_crc;
	assign tx_new   = hcfc_pkg::crc_fold(tx_base, item.data);
	assign rx_new   = hcfc_pkg::crc_fold(st.rx_crc, item.data);
	// without first the header slot is skipped
	assign slot     = idx + {1'b0, ~item.first};
	assign last_idx = {1'b0, item.first} + {1'b0, item.final_req};

	always_comb begin
		has_res      = 1'b0;
		res.kind     = hcfc_pkg::KIND_TX;
		res.out_byte = item.data;
		res.run_end  = 1'b1;
		st_next      = st;
		case (item.cmd)
			hcfc_pkg::CMD_TX: begin
				has_res        = 1'b1;
				st_next.tx_crc = tx_new;
				res.run_end    = (idx == last_idx);
				case (slot)
					SLOT_HDR:  res.out_byte = hcfc_pkg::FRAME_HEADER;
					SLOT_DATA: res.out_byte = item.data;
					SLOT_CRC:  res.out_byte = tx_new;
					default:   res.out_byte = item.data;
				endcase
			end
			hcfc_pkg::CMD_RX: begin
				if (!st.rx_in_frame) begin
					if (item.data == hcfc_pkg::FRAME_HEADER) begin
						st_next.rx_crc      = hcfc_pkg::HDR_CRC;
						st_next.rx_in_frame = 1'b1;
					end
				end else if (item.data == st.rx_crc) begin
					has_res             = 1'b1;
					res.kind            = hcfc_pkg::KIND_RX_END;
					st_next.rx_crc      = 8'h00;
					st_next.rx_in_frame = 1'b0;
				end else begin
					has_res        = 1'b1;
					res.kind       = hcfc_pkg::KIND_RX_DATA;
					st_next.rx_crc = rx_new;
				end
			end
			hcfc_pkg::CMD_RESTART: begin
				st_next.rx_crc      = 8'h00;
				st_next.rx_in_frame = 1'b0;
			end
			default: begin
				st_next = st;
			end
		endcase
	end

endmodule

/* hdl/hcfc_out_stage.sv */
// output register that drives the result channel
module hcfc_out_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  hcfc_pkg::result_t   res,
	output logic                room,
	hcfc_out_if.source          result
);

	logic              valid_q;
	hcfc_pkg::result_t res_q;

	assign room = ~valid_q | result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (room) begin
			valid_q <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			res_q <= res;
		end
	end

	assign result.valid    = valid_q;
	assign result.kind     = res_q.kind;
	assign result.out_byte = res_q.out_byte;
	assign result.run_end  = res_q.run_end;

endmodule

/* hdl/header_crc8_frame_codec.sv */
// top level of the header crc8 frame codec
// Byte framer/deframer for a serial camera-control link. A transmit item (cmd 0) sends its
// data byte; with first set the header byte 0xCC goes out ahead of it and the crc restarts,
// and with final_req set the crc-8/dvb-s2 (poly 0xd5, init 0) over header, command and
// parameters follows it. A receive item (cmd 1) hunts for the header, then gives each byte
// that differs from the running crc as payload and a byte equal to it as a valid frame end.
// A restart item (cmd 2) drops the receive frame. Items go into a stage 1 register, results
// leave through an output register, one result per cycle unless the result channel stalls;
// run_end marks the last result of an item. Throughput is one item per cycle for receive,
// restart and plain transmit items unless stalled; a transmit item with first or final_req
// gives more results and holds stage 1 until its last one is pushed, as the output register
// takes one result per clock. The first result of an item passes through the stage 1 and
// output registers. The crc update is a single byte-wide fold per cycle.
module header_crc8_frame_codec (
	input  logic        clk,
	input  logic        arst_n,
	hcfc_in_if.sink     request,
	hcfc_out_if.source  result
);

	// stage 1: item under work
	logic              valid_s1;
	hcfc_pkg::item_t   item_s1;
	logic [1:0]        idx_q;     // result index within the item
	hcfc_pkg::state_t  state_q;   // crc and frame state

	logic              has_res;
	hcfc_pkg::result_t res;
	hcfc_pkg::state_t  st_next;
	logic              room;
	logic              push;
	logic              retire;

	hcfc_calc u_calc (
		.item    (item_s1),
		.st      (state_q),
		.idx     (idx_q),
		.has_res (has_res),
		.res     (res),
		.st_next (st_next)
	);

	// one result per cycle into the output register while it has room
	assign push   = valid_s1 & has_res & room;
	// item leaves stage 1 once its last result is pushed, or at once if it has none
	assign retire = valid_s1 & (~has_res | (push & res.run_end));

	assign request.ready = ~valid_s1 | retire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			idx_q    <= 2'd0;
			state_q  <= '0;
		end else begin
			if (request.ready) begin
				valid_s1 <= request.valid;
			end
			if (push) begin
				idx_q <= res.run_end ? 2'd0 : idx_q + 2'd1;
			end
			// state moves only when the whole item is done, so its results all see the same state
			if (retire) begin
				state_q <= st_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (request.valid && request.ready) begin
			item_s1.cmd       <= request.cmd;
			item_s1.data      <= request.data;
			item_s1.first     <= request.first;
			item_s1.final_req <= request.final_req;
		end
	end

	hcfc_out_stage u_out_stage (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.res    (res),
		.room   (room),
		.result (result)
	);

endmodule

/* hdl/hcfc_checker.sv */
// port-level checks for the header crc8 frame codec, bound to the top level
module hcfc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_ready,
	input logic [1:0] kind,
	input logic [7:0] out_byte,
	input logic       run_end
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result valid dropped while stalled");

	a_hold_payload: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(kind) && $stable(out_byte) && $stable(run_end))
		else $error("result payload changed while stalled");

	a_rx_single: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (kind == hcfc_pkg::KIND_RX_DATA || kind == hcfc_pkg::KIND_RX_END)
		|-> run_end)
		else $error("receive result not marked as last of its item");

	a_tx_chain: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready && kind == hcfc_pkg::KIND_TX && !run_end
		|=> res_valid && kind == hcfc_pkg::KIND_TX)
		else $error("transmit frame bytes not sent back to back");

endmodule

bind header_crc8_frame_codec hcfc_checker u_hcfc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (result.valid),
	.res_ready (result.ready),
	.kind      (result.kind),
	.out_byte  (result.out_byte),
	.run_end   (result.run_end)
);
